@@ rtl/point_segment_distance_core_defines.svh @@
// ----------------------------------------------------------------------------
// Point-segment distance core assertion macros
// Shared assertion wrappers for the checker of the distance core.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_CORE_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_CORE_DEFINES_SVH

// Assertion that is disabled while reset is asserted.
`define PSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is asserted.
`define PSD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// Point-segment distance package
// Case codes and fixed constants shared by the distance core.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int T_BITS    = 16;
    localparam int DIST_BITS = 25;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {
        CASE_DEGEN  = 2'd0,
        CASE_BEFORE = 2'd1,
        CASE_BEYOND = 2'd2,
        CASE_ON     = 2'd3
    } case_t;

endpackage

@@ rtl/point_segment_distance_core.sv @@
// ----------------------------------------------------------------------------
// Point-segment distance core
// Point to segment distance in fixed point, one item per cycle when not stalled.
// ----------------------------------------------------------------------------
// Channel  Handshake             Fields
// in       in_valid / in_stall   point_x, point_y, start_x, start_y, end_x, end_y
// out      out_valid / out_stall dist_fixed, case_code
//
// One item enters per cycle while in_stall is low.
// The divider cells lie between stages 3 and 4, the square root cells between 7 and 8.
// Each stage holds its item while the next stage is full and stalled.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module point_segment_distance_core
    import psd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic signed [COORD_BITS-1:0] end_x,
    input  logic signed [COORD_BITS-1:0] end_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [DIST_BITS-1:0]         dist_fixed,
    output logic [1:0]                   case_code
);

    localparam int CW    = COORD_BITS;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int L2W   = 2 * CW + 1;
    localparam int RW    = L2W + 1;
    localparam int QW    = T_BITS + 2;
    localparam int TW    = T_BITS + 1;
    localparam int VW    = DW + TW;
    localparam int M     = VW - 1;
    localparam int H     = (M + 1) / 2;
    localparam int HI    = M - H;
    localparam int SQW   = 2 * M;
    localparam int SUMW  = 2 * M + 1;
    localparam int R     = M + 1;
    localparam int SH    = T_BITS - FRAC_BITS;
    localparam int SW    = 2 + 4 * DW;
    localparam int N_DIV = QW;

    logic s1_ld, s2_ld, s3_ld, s4_ld, s5_ld, s6_ld, s7_ld, s8_ld;
    logic div_load [0:N_DIV];
    logic sq_load  [0:R];

    // Stage 1: differences.
    logic                 s1_v_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg, s1_qx_reg, s1_qy_reg, s1_ex_reg, s1_ey_reg;

    assign s1_ld    = !s1_v_reg || s2_ld;
    assign in_stall = !s1_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (s1_ld)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ld)
        begin
            s1_dx_reg <= DW'(end_x) - DW'(start_x);
            s1_dy_reg <= DW'(end_y) - DW'(start_y);
            s1_qx_reg <= DW'(point_x) - DW'(start_x);
            s1_qy_reg <= DW'(point_y) - DW'(start_y);
            s1_ex_reg <= DW'(point_x) - DW'(end_x);
            s1_ey_reg <= DW'(point_y) - DW'(end_y);
        end
    end

    // Stage 2: products.
    logic                 s2_v_reg;
    logic signed [PW-1:0] s2_xx_reg, s2_yy_reg, s2_qdx_reg, s2_qdy_reg;
    logic signed [DW-1:0] s2_dx_reg, s2_dy_reg, s2_qx_reg, s2_qy_reg, s2_ex_reg, s2_ey_reg;

    assign s2_ld = !s2_v_reg || s3_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (s2_ld)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ld)
        begin
            s2_xx_reg  <= s1_dx_reg * s1_dx_reg;
            s2_yy_reg  <= s1_dy_reg * s1_dy_reg;
            s2_qdx_reg <= s1_qx_reg * s1_dx_reg;
            s2_qdy_reg <= s1_qy_reg * s1_dy_reg;
            s2_dx_reg  <= s1_dx_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_qx_reg  <= s1_qx_reg;
            s2_qy_reg  <= s1_qy_reg;
            s2_ex_reg  <= s1_ex_reg;
            s2_ey_reg  <= s1_ey_reg;
        end
    end

    // Stage 3: squared length, dot product and case selection.
    logic                 s3_v_reg;
    case_t                s3_code_reg;
    logic [L2W-1:0]       s3_l2_reg;
    logic [RW-1:0]        s3_dot_reg;
    logic signed [DW-1:0] s3_dx_reg, s3_dy_reg, s3_bx_reg, s3_by_reg;
    logic [PW-1:0]        l2_sum;
    logic signed [PW-1:0] dot_sum;
    case_t                code_next;

    always_comb
    begin
        l2_sum  = s2_xx_reg + s2_yy_reg;
        dot_sum = s2_qdx_reg + s2_qdy_reg;
        if (l2_sum == '0)
        begin
            code_next = CASE_DEGEN;
        end
        else if (dot_sum < 0)
        begin
            code_next = CASE_BEFORE;
        end
        else if (dot_sum > $signed(l2_sum))
        begin
            code_next = CASE_BEYOND;
        end
        else
        begin
            code_next = CASE_ON;
        end
    end

    assign s3_ld = !s3_v_reg || div_load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (s3_ld)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ld)
        begin
            s3_code_reg <= code_next;
            s3_l2_reg   <= l2_sum[L2W-1:0];
            s3_dot_reg  <= dot_sum[RW-1:0];
            s3_dx_reg   <= s2_dx_reg;
            s3_dy_reg   <= s2_dy_reg;
            s3_bx_reg   <= (code_next == CASE_BEYOND) ? s2_ex_reg : s2_qx_reg;
            s3_by_reg   <= (code_next == CASE_BEYOND) ? s2_ey_reg : s2_qy_reg;
        end
    end

    // Divider chain: quotient of dot by squared length.
    logic          div_vld  [0:N_DIV];
    logic [RW-1:0] div_rem  [0:N_DIV];
    logic [RW-2:0] div_den  [0:N_DIV];
    logic [QW-1:0] div_q    [0:N_DIV];
    logic [SW-1:0] div_side [0:N_DIV];

    assign div_vld[0]      = s3_v_reg;
    assign div_rem[0]      = s3_dot_reg;
    assign div_den[0]      = s3_l2_reg;
    assign div_q[0]        = '0;
    assign div_side[0]     = {s3_code_reg, s3_dx_reg, s3_dy_reg, s3_bx_reg, s3_by_reg};
    assign div_load[N_DIV] = s4_ld;

    for (genvar i = 0; i < N_DIV; i++)
    begin : g_div
        psd_div_cell #(
            .RW(RW),
            .QW(QW),
            .SW(SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (div_vld[i]),
            .load_dn  (div_load[i+1]),
            .rem_in   (div_rem[i]),
            .den_in   (div_den[i]),
            .q_in     (div_q[i]),
            .side_in  (div_side[i]),
            .vld_out  (div_vld[i+1]),
            .load_up  (div_load[i]),
            .rem_out  (div_rem[i+1]),
            .den_out  (div_den[i+1]),
            .q_out    (div_q[i+1]),
            .side_out (div_side[i+1])
        );
    end

    // Stage 4: rounded t and error vector.
    logic                  s4_v_reg;
    case_t                 s4_code_reg;
    logic signed [VW-1:0]  s4_vx_reg, s4_vy_reg;
    case_t                 d_code;
    logic [1:0]            d_code_bits;
    logic signed [DW-1:0]  d_dx, d_dy, d_bx, d_by;
    logic [QW:0]           q_inc;
    logic [TW-1:0]         t_eff;
    logic signed [VW:0]    prod_x, prod_y, base_x, base_y, err_x, err_y;

    always_comb
    begin
        {d_code_bits, d_dx, d_dy, d_bx, d_by} = div_side[N_DIV];
        d_code = case_t'(d_code_bits);
        q_inc  = {1'b0, div_q[N_DIV]} + 1'b1;
        t_eff  = (d_code == CASE_ON) ? q_inc[TW:1] : '0;
        prod_x = d_dx * $signed({1'b0, t_eff});
        prod_y = d_dy * $signed({1'b0, t_eff});
        base_x = (VW + 1)'(d_bx) <<< T_BITS;
        base_y = (VW + 1)'(d_by) <<< T_BITS;
        err_x  = base_x - prod_x;
        err_y  = base_y - prod_y;
    end

    assign s4_ld = !s4_v_reg || s5_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (s4_ld)
        begin
            s4_v_reg <= div_vld[N_DIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ld)
        begin
            s4_code_reg <= d_code;
            s4_vx_reg   <= err_x[VW-1:0];
            s4_vy_reg   <= err_y[VW-1:0];
        end
    end

    // Stage 5: magnitudes split into partial products.
    logic              s5_v_reg;
    case_t             s5_code_reg;
    logic [2*HI-1:0]   s5_xhh_reg, s5_yhh_reg;
    logic [HI+H-1:0]   s5_xhl_reg, s5_yhl_reg;
    logic [2*H-1:0]    s5_xll_reg, s5_yll_reg;
    logic [VW-1:0]     neg_x, neg_y;
    logic [M-1:0]      mag_x, mag_y;

    always_comb
    begin
        neg_x = s4_vx_reg[VW-1] ? (-s4_vx_reg) : s4_vx_reg;
        neg_y = s4_vy_reg[VW-1] ? (-s4_vy_reg) : s4_vy_reg;
        mag_x = neg_x[M-1:0];
        mag_y = neg_y[M-1:0];
    end

    assign s5_ld = !s5_v_reg || s6_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg <= 1'b0;
        end
        else if (s5_ld)
        begin
            s5_v_reg <= s4_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_ld)
        begin
            s5_code_reg <= s4_code_reg;
            s5_xhh_reg  <= mag_x[M-1:H] * mag_x[M-1:H];
            s5_xhl_reg  <= mag_x[M-1:H] * mag_x[H-1:0];
            s5_xll_reg  <= mag_x[H-1:0] * mag_x[H-1:0];
            s5_yhh_reg  <= mag_y[M-1:H] * mag_y[M-1:H];
            s5_yhl_reg  <= mag_y[M-1:H] * mag_y[H-1:0];
            s5_yll_reg  <= mag_y[H-1:0] * mag_y[H-1:0];
        end
    end

    // Stage 6: squares.
    logic           s6_v_reg;
    case_t          s6_code_reg;
    logic [SQW-1:0] s6_sqx_reg, s6_sqy_reg;

    assign s6_ld = !s6_v_reg || s7_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_v_reg <= 1'b0;
        end
        else if (s6_ld)
        begin
            s6_v_reg <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_ld)
        begin
            s6_code_reg <= s5_code_reg;
            s6_sqx_reg  <= (SQW'(s5_xhh_reg) << (2 * H)) + (SQW'(s5_xhl_reg) << (H + 1))
                           + SQW'(s5_xll_reg);
            s6_sqy_reg  <= (SQW'(s5_yhh_reg) << (2 * H)) + (SQW'(s5_yhl_reg) << (H + 1))
                           + SQW'(s5_yll_reg);
        end
    end

    // Stage 7: squared distance.
    logic            s7_v_reg;
    case_t           s7_code_reg;
    logic [SUMW-1:0] s7_sum_reg;

    assign s7_ld = !s7_v_reg || sq_load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_v_reg <= 1'b0;
        end
        else if (s7_ld)
        begin
            s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s7_ld)
        begin
            s7_code_reg <= s6_code_reg;
            s7_sum_reg  <= SUMW'(s6_sqx_reg) + SUMW'(s6_sqy_reg);
        end
    end

    // Square root chain.
    logic           sq_vld  [0:R];
    logic [2*R-1:0] sq_rad  [0:R];
    logic [R+1:0]   sq_rem  [0:R];
    logic [R-1:0]   sq_root [0:R];
    logic [1:0]     sq_side [0:R];

    assign sq_vld[0]  = s7_v_reg;
    assign sq_rad[0]  = (2 * R)'(s7_sum_reg);
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = s7_code_reg;
    assign sq_load[R] = s8_ld;

    for (genvar j = 0; j < R; j++)
    begin : g_sqrt
        psd_sqrt_cell #(
            .R (R),
            .SW(2)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .vld_in   (sq_vld[j]),
            .load_dn  (sq_load[j+1]),
            .rad_in   (sq_rad[j]),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .side_in  (sq_side[j]),
            .vld_out  (sq_vld[j+1]),
            .load_up  (sq_load[j]),
            .rad_out  (sq_rad[j+1]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1]),
            .side_out (sq_side[j+1])
        );
    end

    // Stage 8: scaling, saturation and output register.
    logic                 s8_v_reg;
    logic [1:0]           s8_code_reg;
    logic [DIST_BITS-1:0] s8_dist_reg;
    logic [R-1:0]         root_sh;
    logic [DIST_BITS-1:0] dist_next;

    always_comb
    begin
        root_sh   = sq_root[R] >> SH;
        dist_next = (root_sh > R'(DIST_MAX)) ? DIST_MAX : root_sh[DIST_BITS-1:0];
    end

    assign s8_ld = !s8_v_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s8_v_reg <= 1'b0;
        end
        else if (s8_ld)
        begin
            s8_v_reg <= sq_vld[R];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s8_ld)
        begin
            s8_code_reg <= sq_side[R];
            s8_dist_reg <= dist_next;
        end
    end

    assign out_valid  = s8_v_reg;
    assign dist_fixed = s8_dist_reg;
    assign case_code  = s8_code_reg;

endmodule

@@ rtl/psd_div_cell.sv @@
// ----------------------------------------------------------------------------
// Restoring division cell
// Produces one quotient bit per cell and hands the partial remainder on.
// ----------------------------------------------------------------------------
module psd_div_cell #(
    parameter int RW = 34,
    parameter int QW = 18,
    parameter int SW = 70
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          vld_in,
    input  logic          load_dn,
    input  logic [RW-1:0] rem_in,
    input  logic [RW-2:0] den_in,
    input  logic [QW-1:0] q_in,
    input  logic [SW-1:0] side_in,
    output logic          vld_out,
    output logic          load_up,
    output logic [RW-1:0] rem_out,
    output logic [RW-2:0] den_out,
    output logic [QW-1:0] q_out,
    output logic [SW-1:0] side_out
);

    logic          vld_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-2:0] den_reg;
    logic [QW-1:0] q_reg;
    logic [SW-1:0] side_reg;
    logic          bit_q;
    logic [RW-1:0] diff;
    logic [RW-1:0] rem_next;
    logic [QW-1:0] q_next;

    always_comb
    begin
        bit_q    = rem_in >= {1'b0, den_in};
        diff     = bit_q ? (rem_in - {1'b0, den_in}) : rem_in;
        rem_next = {diff[RW-2:0], 1'b0};
        q_next   = {q_in[QW-2:0], bit_q};
    end

    assign load_up = !vld_reg || load_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load_up)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_up)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/psd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// Takes two radicand bits and decides one root bit per cell.
// ----------------------------------------------------------------------------
module psd_sqrt_cell #(
    parameter int R  = 34,
    parameter int SW = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vld_in,
    input  logic            load_dn,
    input  logic [2*R-1:0]  rad_in,
    input  logic [R+1:0]    rem_in,
    input  logic [R-1:0]    root_in,
    input  logic [SW-1:0]   side_in,
    output logic            vld_out,
    output logic            load_up,
    output logic [2*R-1:0]  rad_out,
    output logic [R+1:0]    rem_out,
    output logic [R-1:0]    root_out,
    output logic [SW-1:0]   side_out
);

    logic           vld_reg;
    logic [2*R-1:0] rad_reg;
    logic [R+1:0]   rem_reg;
    logic [R-1:0]   root_reg;
    logic [SW-1:0]  side_reg;
    logic [R+3:0]   cur;
    logic [R+3:0]   trial;
    logic           fits;
    logic [R+3:0]   left;

    always_comb
    begin
        cur   = {rem_in, rad_in[2*R-1:2*R-2]};
        trial = {2'b00, root_in, 2'b01};
        fits  = cur >= trial;
        left  = fits ? (cur - trial) : cur;
    end

    assign load_up = !vld_reg || load_dn;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load_up)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_up)
        begin
            rad_reg  <= {rad_in[2*R-3:0], 2'b00};
            rem_reg  <= left[R+1:0];
            root_reg <= {root_in[R-2:0], fits};
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

@@ rtl/psd_checker.sv @@
// ----------------------------------------------------------------------------
// Point-segment distance checker
// Port-level checks on the distance core, attached by bind.
// ----------------------------------------------------------------------------
`include "point_segment_distance_core_defines.svh"

module psd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [24:0] dist_fixed,
    input logic [1:0]  case_code
);

    // A stalled result keeps its valid and its fields.
    `PSD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(dist_fixed) && $stable(case_code), "stalled result changed")

    // The input side only stalls when the output side stalls.
    `PSD_ASSERT(a_no_stall_free, clk, rst_n, !out_stall |-> !in_stall, "input stalled with free output")

    // An empty output stage never back-pressures the input.
    `PSD_ASSERT(a_empty_out, clk, rst_n, !out_valid |-> !in_stall, "input stalled with empty output")

    // Reset leaves no result pending.
    `PSD_ASSERT_RST(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind point_segment_distance_core psd_checker u_psd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dist_fixed (dist_fixed),
    .case_code  (case_code)
);
